FILE: rtl/tas_pkg.sv
package tas_pkg;

  localparam int NUM_TASKS = 8;
  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W = $clog2(NUM_TASKS + 1);
  localparam int MASK_SRC_W = (NUM_TASKS > 8) ? NUM_TASKS : 8;

  localparam logic [2:0] MODE_TICK      = 3'd0;
  localparam logic [2:0] MODE_SEC_TICK  = 3'd1;
  localparam logic [2:0] MODE_ARM_TICK  = 3'd2;
  localparam logic [2:0] MODE_ARM_SEC   = 3'd3;
  localparam logic [2:0] MODE_SET_READY = 3'd4;
  localparam logic [2:0] MODE_CANCEL    = 3'd5;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan;
    logic finish;
    logic load;
  } tas_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } tas_stat_t;

endpackage

FILE: rtl/task_alarm_scheduler.sv
// an item passes the exec and done states before out_valid is set; items that need a table scan
// (expiry, seconds match or wake recompute) also pass the scan and finish states in between
// one item is held at a time: a new item is taken only once the last result has been loaded;
// the scan visits one task entry a cycle, set by the single shared compare and min unit
// reset: synchronous, clears ready and armed flags, counters, wake value and out_valid;
// alarm values stay unset until armed
module task_alarm_scheduler
  import tas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [2:0]  task_index,
  input  logic [15:0] tick_delay,
  input  logic [15:0] second_delay,
  input  logic        make_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  ready_mask,
  output logic [15:0] tick_now,
  output logic [31:0] seconds_now,
  output logic [15:0] next_wake,
  output logic [3:0]  pending_alarms
);

  tas_cmd_t  cmd;
  tas_stat_t stat;

  tas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tas_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .mode           (mode),
    .task_index     (task_index),
    .tick_delay     (tick_delay),
    .second_delay   (second_delay),
    .make_ready     (make_ready),
    .ready_mask     (ready_mask),
    .tick_now       (tick_now),
    .seconds_now    (seconds_now),
    .next_wake      (next_wake),
    .pending_alarms (pending_alarms)
  );

endmodule

FILE: rtl/tas_ctrl.sv
module tas_ctrl
  import tas_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  tas_stat_t stat,
  output tas_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd         = '0;
    cmd.capture = in_valid && (state == S_IDLE);
    cmd.exec    = (state == S_EXEC);
    cmd.scan    = (state == S_SCAN);
    cmd.finish  = (state == S_FIN);
    cmd.load    = (state == S_DONE) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: state_next = stat.need_scan ? S_SCAN : S_DONE;
      S_SCAN: if (stat.scan_last) state_next = S_FIN;
      S_FIN:  state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/tas_datapath.sv
module tas_datapath
  import tas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  tas_cmd_t    cmd,
  output tas_stat_t   stat,
  input  logic [2:0]  mode,
  input  logic [2:0]  task_index,
  input  logic [15:0] tick_delay,
  input  logic [15:0] second_delay,
  input  logic        make_ready,
  output logic [7:0]  ready_mask,
  output logic [15:0] tick_now,
  output logic [31:0] seconds_now,
  output logic [15:0] next_wake,
  output logic [3:0]  pending_alarms
);

  logic [2:0]           op_mode;
  logic [2:0]           op_task;
  logic [15:0]          op_tdel;
  logic [15:0]          op_sdel;
  logic                 op_mk;

  logic [NUM_TASKS-1:0] ready_flag;
  logic [NUM_TASKS-1:0] tick_armed;
  logic [NUM_TASKS-1:0] seconds_armed;
  logic [15:0]          tick_target [NUM_TASKS];
  logic [31:0]          sec_target [NUM_TASKS];
  logic [15:0]          tick_counter;
  logic [31:0]          seconds_counter;
  logic [15:0]          wake_tick;
  logic [CNT_W-1:0]     armed_count;

  logic [IDX_W-1:0]     scan_idx;
  logic                 scan_sec;
  logic                 scan_expire;
  logic [15:0]          best;

  logic [IDX_W-1:0]     task_sel;
  logic                 task_ok;
  logic [15:0]          tick_inc;
  logic                 sec_hit;
  logic                 tick_fire;
  logic [15:0]          ticks_left;
  logic [MASK_SRC_W-1:0] mask_src;

  assign task_sel   = IDX_W'(op_task);
  assign task_ok    = 32'(op_task) < NUM_TASKS;
  assign tick_inc   = tick_counter + 16'd1;
  assign sec_hit    = seconds_armed[scan_idx] && (sec_target[scan_idx] == seconds_counter);
  assign tick_fire  = scan_expire && tick_armed[scan_idx]
                      && (tick_target[scan_idx] == tick_counter);
  assign ticks_left = tick_target[scan_idx] - tick_counter;

  always_comb begin
    stat.scan_last = (scan_idx == IDX_W'(NUM_TASKS - 1));
    stat.need_scan = 1'b0;
    unique case (op_mode)
      MODE_TICK:      stat.need_scan = (armed_count != '0) && (tick_inc == wake_tick);
      MODE_SEC_TICK:  stat.need_scan = 1'b1;
      MODE_ARM_TICK:  stat.need_scan = task_ok;
      MODE_SET_READY: stat.need_scan = task_ok && tick_armed[task_sel];
      MODE_CANCEL:    stat.need_scan = task_ok && tick_armed[task_sel];
      default:        stat.need_scan = 1'b0;
    endcase
  end

  // captured item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_mode <= mode;
      op_task <= task_index;
      op_tdel <= tick_delay;
      op_sdel <= second_delay;
      op_mk   <= make_ready;
    end
  end

  // per-task alarm values
  always_ff @(posedge clk) begin
    if (cmd.exec && task_ok) begin
      if (op_mode == MODE_ARM_TICK) begin
        tick_target[task_sel] <= tick_counter + op_tdel;
      end
      if (op_mode == MODE_ARM_SEC) begin
        sec_target[task_sel] <= seconds_counter + {16'd0, op_sdel};
      end
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      scan_idx    <= '0;
      scan_sec    <= (op_mode == MODE_SEC_TICK);
      scan_expire <= (op_mode == MODE_TICK);
      best        <= 16'hFFFF;
    end else if (cmd.scan) begin
      scan_idx <= scan_idx + IDX_W'(1);
      if (!scan_sec && !tick_fire && tick_armed[scan_idx] && (ticks_left < best)) begin
        best <= ticks_left;
      end
    end
  end

  // task flags and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      ready_flag      <= '0;
      tick_armed      <= '0;
      seconds_armed   <= '0;
      tick_counter    <= '0;
      seconds_counter <= '0;
      wake_tick       <= '0;
      armed_count     <= '0;
    end else if (cmd.exec) begin
      unique case (op_mode)
        MODE_TICK: begin
          tick_counter <= tick_inc;
        end
        MODE_SEC_TICK: begin
          seconds_counter <= seconds_counter + 32'd1;
        end
        MODE_ARM_TICK: begin
          if (task_ok) begin
            ready_flag[task_sel] <= 1'b0;
            if (!tick_armed[task_sel]) begin
              tick_armed[task_sel] <= 1'b1;
              armed_count          <= armed_count + CNT_W'(1);
            end
          end
        end
        MODE_ARM_SEC: begin
          if (task_ok) begin
            seconds_armed[task_sel] <= 1'b1;
            ready_flag[task_sel]    <= 1'b0;
          end
        end
        MODE_SET_READY: begin
          if (task_ok) begin
            seconds_armed[task_sel] <= 1'b0;
            ready_flag[task_sel]    <= op_mk;
            if (tick_armed[task_sel]) begin
              tick_armed[task_sel] <= 1'b0;
              armed_count          <= armed_count - CNT_W'(1);
            end
          end
        end
        MODE_CANCEL: begin
          if (task_ok && tick_armed[task_sel]) begin
            tick_armed[task_sel] <= 1'b0;
            armed_count          <= armed_count - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.scan) begin
      if (scan_sec) begin
        if (sec_hit) begin
          ready_flag[scan_idx]    <= 1'b1;
          seconds_armed[scan_idx] <= 1'b0;
        end
      end else if (tick_fire) begin
        ready_flag[scan_idx] <= 1'b1;
        tick_armed[scan_idx] <= 1'b0;
        armed_count          <= armed_count - CNT_W'(1);
      end
    end else if (cmd.finish) begin
      if (!scan_sec && (armed_count != '0)) begin
        wake_tick <= tick_counter + best;
      end
    end
  end

  // result register
  assign mask_src = MASK_SRC_W'(ready_flag);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ready_mask     <= mask_src[7:0];
      tick_now       <= tick_counter;
      seconds_now    <= seconds_counter;
      next_wake      <= wake_tick;
      pending_alarms <= 4'(armed_count);
    end
  end

endmodule

FILE: rtl/tas_checker.sv
module tas_checker
  import tas_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  ready_mask,
  input logic [15:0] tick_now,
  input logic [31:0] seconds_now,
  input logic [15:0] next_wake,
  input logic [3:0]  pending_alarms
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ready_mask) && $stable(tick_now)
      && $stable(seconds_now) && $stable(next_wake) && $stable(pending_alarms))
    else $error("stalled result changed");

  // one item at a time
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  // pending count never exceeds the table size
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(pending_alarms) <= NUM_TASKS)
    else $error("pending count out of range");

  // no result straight after reset
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind task_alarm_scheduler tas_checker u_tas_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .ready_mask     (ready_mask),
  .tick_now       (tick_now),
  .seconds_now    (seconds_now),
  .next_wake      (next_wake),
  .pending_alarms (pending_alarms)
);

FILE: sim/task_alarm_checker.sv
`timescale 1ns / 100ps

module task_alarm_checker
  import tas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [2:0]  task_index,
  input  logic [15:0] tick_delay,
  input  logic [15:0] second_delay,
  input  logic        make_ready,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  ready_mask,
  input  logic [15:0] tick_now,
  input  logic [31:0] seconds_now,
  input  logic [15:0] next_wake,
  input  logic [3:0]  pending_alarms,
  output int          fault_count,
  output int          status_backlog
);

  typedef struct packed {
    logic [7:0]  mask;
    logic [15:0] ticks;
    logic [31:0] secs;
    logic [15:0] wake;
    logic [3:0]  pending;
  } sched_status_t;

  sched_status_t expected_status[$];

  logic [NUM_TASKS-1:0] runnable;
  logic [NUM_TASKS-1:0] tick_pending;
  logic [NUM_TASKS-1:0] sec_pending;
  logic [15:0]          tick_target [NUM_TASKS];
  logic [31:0]          sec_alarm [NUM_TASKS];
  logic [15:0]          tick_value;
  logic [31:0]          sec_count;
  logic [15:0]          wake_at;
  logic [31:0]          armed_total;

  int faults = 0;
  int backlog = 0;

  assign fault_count    = faults;
  assign status_backlog = backlog;

  function automatic void note_fault(string what, logic [31:0] want, logic [31:0] got);
    faults++;
    if (faults <= 10)
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got)
      note_fault(what, want, got);
  endfunction

  // tick of the soonest tick alarm, chosen by wrapped distance from the current count
  function automatic void refresh_wake();
    logic [15:0] best;
    logic [15:0] ticks_left;
    best = 16'hFFFF;
    if (armed_total == 0)
      return;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (tick_pending[i]) begin
        ticks_left = tick_target[i] - tick_value;
        if (ticks_left < best)
          best = ticks_left;
      end
    end
    wake_at = tick_value + best;
  endfunction

  function automatic void drop_tick_alarm(int idx);
    if (tick_pending[idx]) begin
      tick_pending[idx] = 1'b0;
      armed_total--;
      refresh_wake();
    end
  endfunction

  function automatic sched_status_t advance_scheduler(logic [2:0] m, logic [2:0] idx,
                                                      logic [15:0] td, logic [15:0] sd,
                                                      logic mr);
    sched_status_t st;
    logic          idx_ok;
    idx_ok = (idx < NUM_TASKS);
    if (m == MODE_TICK) begin
      tick_value = tick_value + 16'd1;
      if (armed_total != 0 && tick_value == wake_at) begin
        for (int i = 0; i < NUM_TASKS; i++) begin
          if (tick_pending[i] && tick_target[i] == tick_value) begin
            runnable[i]     = 1'b1;
            tick_pending[i] = 1'b0;
            armed_total--;
          end
        end
        refresh_wake();
      end
    end else if (m == MODE_SEC_TICK) begin
      sec_count = sec_count + 32'd1;
      for (int i = 0; i < NUM_TASKS; i++) begin
        if (sec_pending[i] && sec_alarm[i] == sec_count) begin
          runnable[i]    = 1'b1;
          sec_pending[i] = 1'b0;
        end
      end
    end else if (idx_ok && m == MODE_ARM_TICK) begin
      runnable[idx] = 1'b0;
      if (!tick_pending[idx]) begin
        tick_pending[idx] = 1'b1;
        armed_total++;
      end
      tick_target[idx] = tick_value + td;
      refresh_wake();
    end else if (idx_ok && m == MODE_ARM_SEC) begin
      sec_pending[idx] = 1'b1;
      runnable[idx]    = 1'b0;
      sec_alarm[idx]   = sec_count + {16'd0, sd};
    end else if (idx_ok && m == MODE_SET_READY) begin
      sec_pending[idx] = 1'b0;
      drop_tick_alarm(idx);
      runnable[idx] = mr;
    end else if (idx_ok && m == MODE_CANCEL) begin
      drop_tick_alarm(idx);
    end
    st.mask = '0;
    for (int i = 0; i < NUM_TASKS && i < 8; i++)
      st.mask[i] = runnable[i];
    st.ticks   = tick_value;
    st.secs    = sec_count;
    st.wake    = wake_at;
    st.pending = armed_total[3:0];
    return st;
  endfunction

  always @(posedge clk) begin
    sched_status_t want;
    if (rst) begin
      runnable     = '0;
      tick_pending = '0;
      sec_pending  = '0;
      tick_value   = '0;
      sec_count    = '0;
      wake_at      = '0;
      armed_total  = '0;
      expected_status.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          note_fault("unexpected item", '0, {24'd0, ready_mask});
        end else begin
          want = expected_status.pop_front();
          check_field("ready_mask", want.mask, ready_mask);
          check_field("tick_now", want.ticks, tick_now);
          check_field("seconds_now", want.secs, seconds_now);
          check_field("next_wake", want.wake, next_wake);
          check_field("pending_alarms", want.pending, pending_alarms);
        end
      end
      if (in_valid && in_ready)
        expected_status.push_back(advance_scheduler(mode, task_index, tick_delay,
                                                    second_delay, make_ready));
    end
    backlog = expected_status.size();
  end

endmodule

FILE: sim/task_alarm_scheduler_tb.sv
`timescale 1ns / 100ps

module task_alarm_scheduler_tb;
  import tas_pkg::*;

  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;
  localparam int RANDOM_ITEMS = 700;
  localparam int STALL_LIMIT  = 3000;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  mode;
  logic [2:0]  task_index;
  logic [15:0] tick_delay;
  logic [15:0] second_delay;
  logic        make_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  ready_mask;
  logic [15:0] tick_now;
  logic [31:0] seconds_now;
  logic [15:0] next_wake;
  logic [3:0]  pending_alarms;

  int fault_count;
  int status_backlog;
  int burst_left = 0;
  int quiet_cycles = 0;
  int stall_kind = 0;
  int stall_left = 0;

  task_alarm_scheduler u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .task_index     (task_index),
    .tick_delay     (tick_delay),
    .second_delay   (second_delay),
    .make_ready     (make_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ready_mask     (ready_mask),
    .tick_now       (tick_now),
    .seconds_now    (seconds_now),
    .next_wake      (next_wake),
    .pending_alarms (pending_alarms)
  );

  task_alarm_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .task_index     (task_index),
    .tick_delay     (tick_delay),
    .second_delay   (second_delay),
    .make_ready     (make_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ready_mask     (ready_mask),
    .tick_now       (tick_now),
    .seconds_now    (seconds_now),
    .next_wake      (next_wake),
    .pending_alarms (pending_alarms),
    .fault_count    (fault_count),
    .status_backlog (status_backlog)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls in stretches: always ready, coin toss, mostly ready, long stalls
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 64);
    end
    stall_left--;
    case (stall_kind)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ready <= ($urandom_range(0, 4) != 0);
      end
      default: begin
        out_ready <= ((stall_left % 16) < 3);
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [2:0] m, input logic [2:0] idx,
                           input logic [15:0] td, input logic [15:0] sd, input logic mr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    mode         <= m;
    task_index   <= idx;
    tick_delay   <= td;
    second_delay <= sd;
    make_ready   <= mr;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (status_backlog == 0);
  endtask

  task automatic send_tick();
    send_item(MODE_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic send_random_item();
    int          pick;
    logic [2:0]  m;
    logic [15:0] td;
    logic [15:0] sd;
    pick = $urandom_range(0, 99);
    if (pick < 35)
      m = MODE_TICK;
    else if (pick < 50)
      m = MODE_SEC_TICK;
    else if (pick < 68)
      m = MODE_ARM_TICK;
    else if (pick < 78)
      m = MODE_ARM_SEC;
    else if (pick < 87)
      m = MODE_SET_READY;
    else if (pick < 95)
      m = MODE_CANCEL;
    else
      m = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
    td = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
    sd = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    send_item(m, 3'($urandom), td, sd, 1'($urandom));
  endtask

  initial begin
    int sent;
    int run;
    rst          = 1'b1;
    in_valid     = 1'b0;
    mode         = MODE_TICK;
    task_index   = '0;
    tick_delay   = '0;
    second_delay = '0;
    make_ready   = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed
    send_item(MODE_SET_READY, 3'd0, 16'h0000, 16'h0000, 1'b1);
    send_item(MODE_SET_READY, 3'd7, 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(MODE_ARM_TICK, 3'd7, 16'd3, 16'h0000, 1'b0);
    send_item(MODE_ARM_TICK, 3'd7, 16'd2, 16'h0000, 1'b0);
    send_item(MODE_ARM_TICK, 3'd3, 16'hFFFF, 16'h0000, 1'b0);
    send_item(MODE_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_TICK, 3'd7, 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(MODE_ARM_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_CANCEL, 3'd0, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_CANCEL, 3'd0, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_CANCEL, 3'd3, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_ARM_SEC, 3'd1, 16'h0000, 16'd1, 1'b0);
    send_item(MODE_ARM_SEC, 3'd2, 16'h0000, 16'd0, 1'b0);
    send_item(MODE_SEC_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_ARM_SEC, 3'd4, 16'h0000, 16'hFFFF, 1'b0);
    send_item(MODE_SET_READY, 3'd4, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_ARM_TICK, 3'd5, 16'd1, 16'h0000, 1'b0);
    send_item(MODE_ARM_TICK, 3'd6, 16'd1, 16'h0000, 1'b0);
    send_item(MODE_TICK, 3'd0, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_SET_READY, 3'd2, 16'h0000, 16'h0000, 1'b1);
    send_item(MODE_SPARE_A, 3'd5, 16'hAAAA, 16'h5555, 1'b1);
    send_item(MODE_SPARE_B, 3'd2, 16'h5555, 16'hAAAA, 1'b0);
    send_item(MODE_SET_READY, 3'd7, 16'h0000, 16'h0000, 1'b0);
    hold_until_drained();

    // random, with runs of ticks so that short alarms expire
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        run = $urandom_range(5, 20);
        repeat (run) send_tick();
        sent += run;
      end else begin
        send_random_item();
        sent++;
      end
      if ($urandom_range(0, 199) == 0)
        hold_until_drained();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (status_backlog == 0);
    repeat (NUM_TASKS + 16) @(posedge clk);
    if (fault_count == 0 && status_backlog == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/tas_pkg.sv
rtl/tas_ctrl.sv
rtl/tas_datapath.sv
rtl/task_alarm_scheduler.sv
rtl/tas_checker.sv
sim/task_alarm_checker.sv
sim/task_alarm_scheduler_tb.sv
